FILE: hdl/motor_command_frame_crc16_top_assert.svh
// Assertion macros for the motor command framer.
`ifndef MOTOR_COMMAND_FRAME_CRC16_TOP_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_CRC16_TOP_ASSERT_SVH

`ifndef SYNTH

`define MCFCRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer assertion failed");

`define MCFCRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`else

`define MCFCRC_ASSERT_SAME(label, ante, cons)

`define MCFCRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/mcfcrc_pkg.sv
// Shared types, codes and the CRC step function for the motor command framer.
`default_nettype none

package mcfcrc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SpeedW = 32;
  localparam int unsigned CrcW = 16;
  localparam int unsigned OpW = 2;
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned CntW = 3;

  localparam logic [CrcW-1:0] CRC_POLY = 16'h1021;

  localparam logic [OpW-1:0] OP_DRIVE_ONE = 2'd0;
  localparam logic [OpW-1:0] OP_DRIVE_TWO = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR_ENC = 2'd2;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  localparam logic [RegIdxW-1:0] REG_DEVICE_ADDR = 2'd0;
  localparam logic [RegIdxW-1:0] REG_CMD_DRIVE_FIRST = 2'd1;
  localparam logic [RegIdxW-1:0] REG_CMD_DRIVE_SECOND = 2'd2;
  localparam logic [RegIdxW-1:0] REG_CMD_CLEAR_COUNTS = 2'd3;

  localparam logic [ByteW-1:0] RST_DEVICE_ADDR = 8'd128;
  localparam logic [ByteW-1:0] RST_CMD_DRIVE_FIRST = 8'd35;
  localparam logic [ByteW-1:0] RST_CMD_DRIVE_SECOND = 8'd36;
  localparam logic [ByteW-1:0] RST_CMD_CLEAR_COUNTS = 8'd20;

  localparam logic [CntW-1:0] DRIVE_LAST_CNT = 3'd7;
  localparam logic [CntW-1:0] CLEAR_LAST_CNT = 3'd3;

  typedef enum logic [2:0] {
    SEL_ADDR,
    SEL_CMD,
    SEL_SPEED,
    SEL_CRC_HI,
    SEL_CRC_LO
  } byte_sel_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_e sel;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [CrcW-1:0] crc_feed(logic [CrcW-1:0] acc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = acc ^ {b, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/motor_command_frame_crc16_top.sv
// Each word taken on the slave side is one command request: tuser carries the
// opcode (0 drive motor one, 1 drive motor two, 2 reset encoders, 3 dropped without
// output) and tdata the signed speed. The block sends the frame one byte per word on
// the master side: address, command, four speed bytes for drives, then the CRC-16
// (poly 0x1021, init 0) high and low byte, with tlast on the low CRC byte. A request
// is taken while no frame is in progress, and the output register then moves one
// byte per cycle while the sink does not stall; a dropped request is taken and sends
// no bytes. The next request is taken while the final byte still waits.
`default_nettype none

module motor_command_frame_crc16_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mcfcrc_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [mcfcrc_pkg::ByteW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [mcfcrc_pkg::SpeedW-1:0] s_axis_tdata,   // [31:0] speed_value
  input  wire logic [mcfcrc_pkg::OpW-1:0]    s_axis_tuser,   // [1:0] opcode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [mcfcrc_pkg::ByteW-1:0]       m_axis_tdata,   // [7:0] out_byte
  output logic                               m_axis_tlast
);
  import mcfcrc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mcfcrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_op_i    (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mcfcrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_op_i    (s_axis_tuser),
    .req_speed_i (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`include "motor_command_frame_crc16_top_assert.svh"

  `MCFCRC_ASSERT_SAME(a_emit_into_free, cmd.emit, stat.out_free)
  `MCFCRC_ASSERT_SAME(a_last_is_crc_lo, cmd.emit && cmd.last, cmd.sel == SEL_CRC_LO)
  `MCFCRC_ASSERT_NEXT(a_busy_after_load, cmd.load, !s_axis_tready)

endmodule

`default_nettype wire

FILE: hdl/mcfcrc_ctrl.sv
// Frame sequencer: walks the byte positions of one frame and drives the datapath.
`default_nettype none

module mcfcrc_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    req_valid_i,
  input  wire logic [mcfcrc_pkg::OpW-1:0] req_op_i,
  output logic                         req_ready_o,
  input  wire mcfcrc_pkg::dp_stat_t    stat_i,
  output mcfcrc_pkg::ctrl_cmd_t        cmd_o
);
  import mcfcrc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drive_q, drive_d;
  logic            accept;
  logic            last_pos;
  byte_sel_e       sel;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign last_pos    = drive_q ? (cnt_q == DRIVE_LAST_CNT) : (cnt_q == CLEAR_LAST_CNT);

  always_comb begin
    priority if (cnt_q == 3'd0) begin
      sel = SEL_ADDR;
    end else if (cnt_q == 3'd1) begin
      sel = SEL_CMD;
    end else if (last_pos) begin
      sel = SEL_CRC_LO;
    end else if (drive_q ? (cnt_q == 3'd6) : (cnt_q == 3'd2)) begin
      sel = SEL_CRC_HI;
    end else begin
      sel = SEL_SPEED;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drive_d  = drive_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    cmd_o.sel  = sel;
    cmd_o.last = last_pos;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_op_i != OP_UNUSED)) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEND;
          cnt_d      = '0;
          drive_d    = (req_op_i != OP_CLEAR_ENC);
        end
      end
      ST_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cnt_d      = cnt_q + 3'd1;
          if (last_pos) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drive_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drive_q <= drive_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcfcrc_dp.sv
// Datapath: command registers, speed shifter, CRC accumulator and output word register.
`default_nettype none

module mcfcrc_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mcfcrc_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [mcfcrc_pkg::ByteW-1:0]  cfg_data_i,
  input  wire logic [mcfcrc_pkg::OpW-1:0]    req_op_i,
  input  wire logic [mcfcrc_pkg::SpeedW-1:0] req_speed_i,
  input  wire mcfcrc_pkg::ctrl_cmd_t         cmd_i,
  output mcfcrc_pkg::dp_stat_t               stat_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mcfcrc_pkg::ByteW-1:0]       out_byte_o,
  output logic                               out_last_o
);
  import mcfcrc_pkg::*;

  logic [ByteW-1:0]  addr_q, cmd_one_q, cmd_two_q, cmd_clr_q;
  logic [OpW-1:0]    op_q;
  logic [SpeedW-1:0] spd_q, spd_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_last_q;
  logic [ByteW-1:0]  cmd_byte;
  logic [ByteW-1:0]  cur_byte;
  logic              feed_crc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= RST_DEVICE_ADDR;
      cmd_one_q <= RST_CMD_DRIVE_FIRST;
      cmd_two_q <= RST_CMD_DRIVE_SECOND;
      cmd_clr_q <= RST_CMD_CLEAR_COUNTS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEVICE_ADDR:      addr_q    <= cfg_data_i;
        REG_CMD_DRIVE_FIRST:  cmd_one_q <= cfg_data_i;
        REG_CMD_DRIVE_SECOND: cmd_two_q <= cfg_data_i;
        REG_CMD_CLEAR_COUNTS: cmd_clr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (op_q)
      OP_DRIVE_ONE: cmd_byte = cmd_one_q;
      OP_DRIVE_TWO: cmd_byte = cmd_two_q;
      default:      cmd_byte = cmd_clr_q;
    endcase
  end

  always_comb begin
    feed_crc = 1'b0;
    unique case (cmd_i.sel)
      SEL_ADDR: begin
        cur_byte = addr_q;
        feed_crc = 1'b1;
      end
      SEL_CMD: begin
        cur_byte = cmd_byte;
        feed_crc = 1'b1;
      end
      SEL_SPEED: begin
        cur_byte = spd_q[SpeedW-1 -: ByteW];
        feed_crc = 1'b1;
      end
      SEL_CRC_HI: cur_byte = crc_q[CrcW-1 -: ByteW];
      SEL_CRC_LO: cur_byte = crc_q[ByteW-1:0];
      default:    cur_byte = '0;
    endcase
  end

  always_comb begin
    spd_d = spd_q;
    crc_d = crc_q;
    if (cmd_i.load) begin
      spd_d = req_speed_i;
      crc_d = '0;
    end else if (cmd_i.emit) begin
      if (cmd_i.sel == SEL_SPEED) begin
        spd_d = {spd_q[SpeedW-ByteW-1:0], {ByteW{1'b0}}};
      end
      if (feed_crc) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_op_i;
    end
    spd_q <= spd_d;
    if (cmd_i.emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire
